@@ rtl/wase_pkg.sv @@
// Package for the windowed average state estimator: types, sizes and channel codes.
// No dependencies; every other file in the block imports it.
`default_nettype none

package wase_pkg;

  // Readings held per channel and number of channels
  localparam int WINDOW = 5;
  localparam int NCHAN  = 4;

  // Channel codes, in result order
  localparam int CH_XPOS = 0;
  localparam int CH_YPOS = 1;
  localparam int CH_XVEL = 2;
  localparam int CH_YVEL = 3;

  // Fill count holds 0..WINDOW, write slot holds 0..WINDOW-1
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Exact window sum: magnitude up to WINDOW * 2^31
  localparam int MAG_W = 32 + $clog2(WINDOW);
  localparam int SUM_W = MAG_W + 1;

  // Divider: quotient bits retired per cycle and cycles per division
  localparam int DIV_STEPS = 5;
  localparam int DIV_CYC   = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_W     = DIV_CYC * DIV_STEPS;
  localparam int CYC_W     = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Item codes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  typedef logic signed [31:0]      word_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic  op;
    word_t x_pos;
    word_t y_pos;
    word_t x_vel;
    word_t y_vel;
  } in_t;

  typedef struct packed {
    word_t est_x_pos;
    word_t est_y_pos;
    word_t est_x_vel;
    word_t est_y_vel;
  } out_t;

  // Classified command as queued for the back end
  typedef struct packed {
    logic                   predict;
    word_t [NCHAN-1:0]      meas;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/wase_front.sv @@
// Front end: accepts input words, classifies them and queues commands.
// Depends on wase_pkg.
`default_nettype none

module wase_front
  import wase_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_data,
  output logic      in_full,
  input  wire logic take,
  output logic      head_valid,
  output cmd_t      head
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  cmd_t              cmd;
  logic              push_ok;
  logic              pop_ok;

  // Classify the incoming word
  always_comb begin
    cmd.predict        = (in_data.op == OP_PREDICT);
    cmd.meas[CH_XPOS]  = in_data.x_pos;
    cmd.meas[CH_YPOS]  = in_data.y_pos;
    cmd.meas[CH_XVEL]  = in_data.x_vel;
    cmd.meas[CH_YVEL]  = in_data.y_vel;
  end

  assign in_full    = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = take && head_valid;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push_ok) - QCNT_W'(pop_ok);
    end
  end

  // Store the queued command
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wase_div.sv @@
// Four-lane signed divider by the fill count, DIV_STEPS quotient bits per cycle.
// Truncates toward zero. Depends on wase_pkg.
`default_nettype none

module wase_div
  import wase_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire sum_t [NCHAN-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output word_t [NCHAN-1:0]     quotient
);

  logic [PAD_W-1:0] dq_r    [NCHAN];
  logic [CNT_W-1:0] rem_r   [NCHAN];
  logic             neg_r   [NCHAN];
  logic [PAD_W-1:0] dq_step [NCHAN];
  logic [CNT_W-1:0] rem_step[NCHAN];
  logic [MAG_W-1:0] mag     [NCHAN];
  logic [CNT_W-1:0] divisor_r;
  logic [CYC_W-1:0] cyc_r;
  logic             busy_r;
  logic             done_r;

  // Take the magnitude of each dividend
  always_comb begin
    sum_t neg_sum;
    for (int c = 0; c < NCHAN; c++) begin
      neg_sum = -dividend[c];
      mag[c]  = dividend[c][SUM_W-1] ? neg_sum[MAG_W-1:0] : dividend[c][MAG_W-1:0];
    end
  end

  // Retire DIV_STEPS restoring steps per lane
  always_comb begin
    logic [CNT_W:0]   t;
    logic [PAD_W-1:0] dq;
    logic [CNT_W-1:0] rem;
    logic             qb;
    for (int c = 0; c < NCHAN; c++) begin
      dq  = dq_r[c];
      rem = rem_r[c];
      for (int k = 0; k < DIV_STEPS; k++) begin
        t  = {rem, dq[PAD_W-1]};
        qb = (t >= {1'b0, divisor_r});
        if (qb) begin
          rem = CNT_W'(t - {1'b0, divisor_r});
        end else begin
          rem = t[CNT_W-1:0];
        end
        dq = {dq[PAD_W-2:0], qb};
      end
      dq_step[c]  = dq;
      rem_step[c] = rem;
    end
  end

  // Sequence the division
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cyc_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cyc_r  <= '0;
      end else if (busy_r) begin
        if (cyc_r == CYC_W'(DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cyc_r <= cyc_r + 1'b1;
        end
      end
    end
  end

  // Load or shift the lane registers
  always_ff @(posedge clk) begin
    if (start) begin
      divisor_r <= divisor;
      for (int c = 0; c < NCHAN; c++) begin
        dq_r[c]  <= PAD_W'(mag[c]);
        rem_r[c] <= '0;
        neg_r[c] <= dividend[c][SUM_W-1];
      end
    end else if (busy_r) begin
      for (int c = 0; c < NCHAN; c++) begin
        dq_r[c]  <= dq_step[c];
        rem_r[c] <= rem_step[c];
      end
    end
  end

  // Restore the sign of each quotient
  always_comb begin
    logic [31:0] q;
    for (int c = 0; c < NCHAN; c++) begin
      q           = dq_r[c][31:0];
      quotient[c] = neg_r[c] ? -q : q;
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

@@ rtl/wase_back.sv @@
// Back end: window storage, running sums, estimate update and result register.
// Depends on wase_pkg and wase_div.
`default_nettype none

module wase_back
  import wase_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire cmd_t head,
  output logic      take,
  input  wire logic out_pop,
  output out_t      out_data,
  output logic      out_empty
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_DIV, S_OUT} state_t;

  state_t            state_r;
  word_t             win_r [NCHAN][WINDOW];
  sum_t  [NCHAN-1:0] sum_r;
  sum_t  [NCHAN-1:0] sum_upd;
  word_t [NCHAN-1:0] est_r;
  word_t [NCHAN-1:0] quotient;
  word_t             sat_x;
  word_t             sat_y;
  logic [CNT_W-1:0]  fill_r;
  logic [SLOT_W-1:0] slot_r;
  logic              win_full;
  logic              div_start;
  logic              div_done;
  logic              out_valid_r;
  out_t              out_data_r;
  logic              out_load;

  assign take      = (state_r == S_IDLE) && head_valid;
  assign win_full  = (fill_r == CNT_W'(WINDOW));
  assign div_start = (state_r == S_START);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_pop);

  // Update running sums: add the new reading, drop the one it replaces
  always_comb begin
    sum_t add_v;
    sum_t drop_v;
    for (int c = 0; c < NCHAN; c++) begin
      add_v      = sum_t'(head.meas[c]);
      drop_v     = win_full ? sum_t'(win_r[c][slot_r]) : '0;
      sum_upd[c] = sum_r[c] + add_v - drop_v;
    end
  end

  // Advance positions by velocity with saturation
  always_comb begin
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    sx = {est_r[CH_XPOS][31], est_r[CH_XPOS]} + {est_r[CH_XVEL][31], est_r[CH_XVEL]};
    sy = {est_r[CH_YPOS][31], est_r[CH_YPOS]} + {est_r[CH_YVEL][31], est_r[CH_YVEL]};
    if (sx[32] != sx[31]) begin
      sat_x = sx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_x = sx[31:0];
    end
    if (sy[32] != sy[31]) begin
      sat_y = sy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_y = sy[31:0];
    end
  end

  wase_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequence one command and hold the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      est_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result word, or drop the one just popped
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (head_valid) begin
            if (head.predict) begin
              est_r[CH_XPOS] <= sat_x;
              est_r[CH_YPOS] <= sat_y;
              state_r        <= S_OUT;
            end else begin
              sum_r   <= sum_upd;
              slot_r  <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
              if (!win_full) begin
                fill_r <= fill_r + 1'b1;
              end
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            est_r   <= quotient;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.est_x_pos <= est_r[CH_XPOS];
      out_data_r.est_y_pos <= est_r[CH_YPOS];
      out_data_r.est_x_vel <= est_r[CH_XVEL];
      out_data_r.est_y_vel <= est_r[CH_YVEL];
    end
  end

  // Write the new reading into its window slot
  always_ff @(posedge clk) begin
    if (take && !head.predict) begin
      for (int c = 0; c < NCHAN; c++) begin
        win_r[c][slot_r] <= head.meas[c];
      end
    end
  end

  assign out_data  = out_data_r;
  assign out_empty = !out_valid_r;

`ifndef SYNTH
  // Until the window fills, the write slot tracks the fill count
  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != CNT_W'(WINDOW)) |-> (slot_r == SLOT_W'(fill_r)))
    else $error("write slot out of step with fill count");

  // A measurement goes straight to the divider start
  a_meas_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !head.predict) |=> (state_r == S_START))
    else $error("measurement did not start the divider");

  // The divider finishes only while it is awaited
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside of divide state");

  // A predict tick leaves the velocity estimates alone
  a_predict_keeps_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (take && head.predict) |=>
      (est_r[CH_XVEL] == $past(est_r[CH_XVEL])) &&
      (est_r[CH_YVEL] == $past(est_r[CH_YVEL])))
    else $error("predict tick changed a velocity estimate");
`endif

endmodule

`default_nettype wire

@@ rtl/windowed_average_state_estimator_top.sv @@
// Measurement: the running sums update, then the 4-lane divider loads and steps until done,
// then the result word is loaded. Predict tick: one saturating add, then the result word.
// The back end sequencer takes no new command until its result word is loaded, which waits
// for a free result register; a two-entry command queue takes new words while the back end is busy.
// Reset (synchronous, rst_n low): queue and result register empty, estimates, sums and fill
// count zero; no clearing pass.
`default_nettype none

module windowed_average_state_estimator_top
  import wase_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_data,
  output logic      in_full,
  input  wire logic out_pop,
  output out_t      out_data,
  output logic      out_empty
);

  logic head_valid;
  cmd_t head;
  logic take;

  wase_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .take       (take),
    .head_valid (head_valid),
    .head       (head)
  );

  wase_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .out_empty  (out_empty)
  );

endmodule

`default_nettype wire
